FILE: rtl/h263gp_pkg.sv
// ----------------------------------------------------------------------------
// h263gp_pkg
// Shared types and constants of the H.263 GOB packetizer: the job that the
// front hands to the back through the queue, and the timestamp constants.
// ----------------------------------------------------------------------------
`default_nettype none

package h263gp_pkg;

  // reciprocal of 25 scaled by 2**35, exact for every 31-bit dividend
  localparam logic [30:0] DivMagic  = 31'h51EB851F;
  localparam int unsigned DivShift  = 35;
  localparam int unsigned ProdWidth = 62;

  // one job per input byte that causes results: an unmarked cut packet (slot a)
  // and a closing packet or drop notice (slot b)
  typedef struct packed {
    logic        has_a;
    logic [15:0] a_offset;
    logic [16:0] a_length;
    logic        has_b;
    logic        b_drop;
    logic [15:0] b_offset;
    logic [16:0] b_length;
    logic [31:0] seq_base;
    logic [31:0] header_word;
    logic [30:0] ts_quarter;
  } job_t;

endpackage

`default_nettype wire

FILE: rtl/h263gp_if.sv
// ----------------------------------------------------------------------------
// h263gp channel interfaces
// Byte stream channel into the packetizer and descriptor channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface h263gp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [31:0] frame_number;
  logic [31:0] time_us;

  modport source (output valid, data_byte, last_byte, frame_number, time_us,
                  input ready);
  modport sink   (input valid, data_byte, last_byte, frame_number, time_us,
                  output ready);
endinterface

interface h263gp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] packet_offset;
  logic [16:0] packet_length;
  logic        marker;
  logic [31:0] sequence_number;
  logic [31:0] header_word;
  logic [31:0] rtp_timestamp;
  logic        dropped;
  logic        run_end;

  modport source (output valid, packet_offset, packet_length, marker,
                  sequence_number, header_word, rtp_timestamp, dropped, run_end,
                  input ready);
  modport sink   (input valid, packet_offset, packet_length, marker,
                  sequence_number, header_word, rtp_timestamp, dropped, run_end,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/h263_gob_packetizer.sv
// ----------------------------------------------------------------------------
// h263_gob_packetizer
// H.263 frame byte stream in, RFC 2190 mode A packet descriptors out.
// ----------------------------------------------------------------------------
//
//  channel   dir  transaction              payload
//  bytes_i   in   one frame byte           data_byte, last_byte, frame_number, time_us
//  desc_o    out  one packet descriptor    offset, length, marker, seq, header, ts, flags
//  apb       in   register write / read    max_packet_size @0x0, time_offset_us @0x4
//
//  One byte is taken per cycle while the job queue is not full; a byte that
//  causes two descriptors has them issued one after the other through the
//  single output register. A descriptor reaches desc_o through the queue entry,
//  the job stage with the 90 kHz multiplier and the output register.
//  Reset clears frame state, sequence count and time offset; max_packet_size resets to 1400.
//  bytes_i stalls only when the job queue is full; desc_o stalls back through it.
// ----------------------------------------------------------------------------
`default_nettype none

module h263_gob_packetizer #(
  parameter int unsigned MAX_FRAME_BYTES = 65536,
  parameter int unsigned QUEUE_DEPTH     = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  h263gp_in_if.sink        bytes_i,
  h263gp_out_if.source     desc_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam logic RegMaxPacketSize = 1'b0;
  localparam logic RegTimeOffset    = 1'b1;

  logic [15:0] max_packet_size_q;
  logic [31:0] time_offset_us_q;
  logic        cfg_write;

  logic             push;
  h263gp_pkg::job_t push_data;
  logic             full;
  logic             pop;
  h263gp_pkg::job_t head;
  logic             empty;

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_packet_size_q <= 16'd1400;
      time_offset_us_q  <= '0;
    end else if (cfg_write) begin
      case (paddr[2])
        RegMaxPacketSize: max_packet_size_q <= pwdata[15:0];
        RegTimeOffset:    time_offset_us_q  <= pwdata;
        default:          ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[2])
      RegMaxPacketSize: prdata = {16'b0, max_packet_size_q};
      RegTimeOffset:    prdata = time_offset_us_q;
      default:          prdata = '0;
    endcase
  end

  h263gp_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_chan           (bytes_i),
    .max_packet_size_i (max_packet_size_q),
    .time_offset_us_i  (time_offset_us_q),
    .push_o            (push),
    .push_data_o       (push_data),
    .full_i            (full)
  );

  h263gp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head),
    .empty_o     (empty)
  );

  h263gp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .head_i   (head),
    .pop_o    (pop),
    .out_chan (desc_o)
  );

endmodule

`default_nettype wire

FILE: rtl/h263gp_front.sv
// ----------------------------------------------------------------------------
// h263gp_front
// Takes one frame byte per cycle while the job queue is not full, tracks
// GOB start codes and frame offsets, decides which descriptors a byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module h263gp_front #(
  parameter int unsigned MAX_FRAME_BYTES = 65536
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  h263gp_in_if.sink          in_chan,
  input  wire logic [15:0]   max_packet_size_i,
  input  wire logic [31:0]   time_offset_us_i,
  output      logic          push_o,
  output      h263gp_pkg::job_t push_data_o,
  input  wire logic          full_i
);

  localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned OW = $clog2(MAX_FRAME_BYTES);

  localparam logic [7:0] StartMask      = 8'hfc;
  localparam logic [7:0] StartThreshold = 8'h80;
  localparam logic [7:0] SrcMask        = 8'h1c;
  localparam logic [31:0] ShortSlack    = 32'd4;

  logic [CW-1:0] byte_index_q, byte_index_d;
  logic [OW-1:0] lso_q, lso_d;
  logic [OW-1:0] lgo_q, lgo_d;
  logic [7:0]    prev1_q, prev1_d;
  logic [7:0]    prev2_q, prev2_d;
  logic [7:0]    ptype_a_q, ptype_a_d;
  logic [7:0]    ptype_b_q, ptype_b_d;
  logic [31:0]   seq_inc_q, seq_inc_d;

  logic          accept;
  logic          overrun;
  logic [OW-1:0] idx;
  logic [OW-1:0] gob_pos;
  logic [OW-1:0] gob_span;
  logic          is_gob;
  logic          gob_cut;
  logic [CW-1:0] frame_len;
  logic [CW-1:0] lso_ext;
  logic          end_cut;
  logic          end_cut_pkt;
  logic [OW-1:0] lso_after;
  logic [CW-1:0] tail_len;
  logic          short_drop;
  logic [OW-1:0] pend_len;
  logic [32:0]   ts_sum;
  logic          has_a;
  logic          has_b;
  logic          b_drop;

  // mode A header from the PTYPE bytes
  function automatic logic [31:0] header_of(input logic [7:0] pa, input logic [7:0] pb);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [2:0] src;
    src = 3'((pa & SrcMask) >> 2);
    b0  = {1'b0, pb[5], 6'b0};
    b1  = {src, pa[1], pa[0], pb[7], pb[6], 1'b0};
    return {b0, b1, 16'b0};
  endfunction

  assign in_chan.ready = !full_i;
  assign accept        = in_chan.valid && !full_i;

  // classification of the current byte
  always_comb begin
    overrun   = byte_index_q >= CW'(MAX_FRAME_BYTES);
    idx       = byte_index_q[OW-1:0];
    gob_pos   = idx - OW'(2);
    gob_span  = gob_pos - lso_q;
    is_gob    = !in_chan.last_byte && (prev2_q == 8'h00) && (prev1_q == 8'h00) &&
                ((in_chan.data_byte & StartMask) > StartThreshold);
    gob_cut   = is_gob && (32'(gob_span) >= 32'(max_packet_size_i)) && (lgo_q != '0);
    frame_len = byte_index_q + CW'(1);
    lso_ext   = CW'(lso_q);
    end_cut   = (lso_q != '0) &&
                (32'(frame_len - lso_ext) >= 32'(max_packet_size_i));
    end_cut_pkt = end_cut && (lgo_q > lso_q);
    lso_after = end_cut ? lgo_q : lso_q;
    tail_len  = frame_len - CW'(lso_after);
    short_drop = (lso_q == '0) &&
                 (32'(frame_len) > (32'(max_packet_size_i) + ShortSlack));
    pend_len  = lgo_q - lso_q;
    ts_sum    = {1'b0, in_chan.time_us} + {1'b0, time_offset_us_i};
  end

  // job decision
  always_comb begin
    has_a  = 1'b0;
    has_b  = 1'b0;
    b_drop = 1'b0;
    if (overrun) begin
      has_b  = in_chan.last_byte;
      b_drop = 1'b1;
    end else if (in_chan.last_byte) begin
      has_a  = end_cut_pkt;
      has_b  = 1'b1;
      b_drop = short_drop;
    end else begin
      has_a  = gob_cut;
    end
  end

  // next state
  always_comb begin
    byte_index_d = byte_index_q;
    lso_d        = lso_q;
    lgo_d        = lgo_q;
    prev1_d      = prev1_q;
    prev2_d      = prev2_q;
    ptype_a_d    = ptype_a_q;
    ptype_b_d    = ptype_b_q;
    seq_inc_d    = seq_inc_q;
    if (accept) begin
      seq_inc_d = seq_inc_q + 32'(has_a);
      if (!overrun) begin
        if (byte_index_q == CW'(4)) ptype_a_d = in_chan.data_byte;
        if (byte_index_q == CW'(5)) ptype_b_d = in_chan.data_byte;
        if (gob_cut) lso_d = lgo_q;
        if (is_gob) lgo_d = gob_pos;
        prev2_d      = prev1_q;
        prev1_d      = in_chan.data_byte;
        byte_index_d = frame_len;
      end
      if (in_chan.last_byte) begin
        byte_index_d = '0;
        lso_d        = '0;
        lgo_d        = '0;
        prev1_d      = 8'hff;
        prev2_d      = 8'hff;
        ptype_a_d    = 8'h00;
        ptype_b_d    = 8'h00;
      end
    end
  end

  // job payload
  always_comb begin
    push_o                  = accept && (has_a || has_b);
    push_data_o.has_a       = has_a;
    push_data_o.a_offset    = 16'(lso_q);
    push_data_o.a_length    = 17'(pend_len);
    push_data_o.has_b       = has_b;
    push_data_o.b_drop      = b_drop;
    push_data_o.b_offset    = 16'(lso_after);
    push_data_o.b_length    = 17'(tail_len);
    push_data_o.seq_base    = in_chan.frame_number + seq_inc_q;
    push_data_o.header_word = header_of(
        (!overrun && byte_index_q == CW'(4)) ? in_chan.data_byte : ptype_a_q,
        (!overrun && byte_index_q == CW'(5)) ? in_chan.data_byte : ptype_b_q);
    push_data_o.ts_quarter  = ts_sum[32:2];
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      lso_q        <= '0;
      lgo_q        <= '0;
      prev1_q      <= 8'hff;
      prev2_q      <= 8'hff;
      ptype_a_q    <= 8'h00;
      ptype_b_q    <= 8'h00;
      seq_inc_q    <= '0;
    end else begin
      byte_index_q <= byte_index_d;
      lso_q        <= lso_d;
      lgo_q        <= lgo_d;
      prev1_q      <= prev1_d;
      prev2_q      <= prev2_d;
      ptype_a_q    <= ptype_a_d;
      ptype_b_q    <= ptype_b_d;
      seq_inc_q    <= seq_inc_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/h263gp_fifo.sv
// ----------------------------------------------------------------------------
// h263gp_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module h263gp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire h263gp_pkg::job_t push_data_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      h263gp_pkg::job_t pop_data_o,
  output      logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  h263gp_pkg::job_t slots_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] count_q, count_d;

  assign full_o     = count_q == NW'(DEPTH);
  assign empty_o    = count_q == '0;
  assign pop_data_o = slots_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) count_d = count_q + NW'(1);
    else if (!push_i && pop_i) count_d = count_q - NW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

FILE: rtl/h263gp_back.sv
// ----------------------------------------------------------------------------
// h263gp_back
// Pulls jobs from the queue, converts the play time to 90 kHz and issues
// one descriptor per cycle through the output register unless desc_o stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module h263gp_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  wire h263gp_pkg::job_t head_i,
  output      logic             pop_o,
  h263gp_out_if.source          out_chan
);

  localparam int unsigned PW = h263gp_pkg::ProdWidth;
  localparam int unsigned DS = h263gp_pkg::DivShift;
  localparam int unsigned QW = PW - DS;

  // job stage
  logic             x_valid_q, x_valid_d;
  logic             x_a_done_q, x_a_done_d;
  h263gp_pkg::job_t x_job_q;
  logic [PW-1:0]    x_prod_q;

  // output register
  logic        o_valid_q, o_valid_d;
  logic [15:0] o_offset_q, o_offset_d;
  logic [16:0] o_length_q, o_length_d;
  logic        o_marker_q, o_marker_d;
  logic [31:0] o_seq_q, o_seq_d;
  logic [31:0] o_header_q, o_header_d;
  logic [31:0] o_ts_q, o_ts_d;
  logic        o_dropped_q, o_dropped_d;
  logic        o_run_end_q, o_run_end_d;

  logic          cur_is_a;
  logic          emit;
  logic          finish;
  logic [QW-1:0] quot;
  logic [31:0]   ts;
  logic [PW-1:0] prod;

  // handshake of the job stage
  always_comb begin
    cur_is_a = x_job_q.has_a && !x_a_done_q;
    emit     = x_valid_q && (!o_valid_q || out_chan.ready);
    finish   = emit && (!cur_is_a || !x_job_q.has_b);
    pop_o    = !empty_i && (!x_valid_q || finish);
    prod     = PW'(head_i.ts_quarter) * PW'(h263gp_pkg::DivMagic);
    quot     = x_prod_q[PW-1:DS];
    ts       = (32'(quot) << 3) + 32'(quot);
  end

  // stage and output next values
  always_comb begin
    x_valid_d   = x_valid_q;
    x_a_done_d  = x_a_done_q;
    o_valid_d   = o_valid_q;
    o_offset_d  = o_offset_q;
    o_length_d  = o_length_q;
    o_marker_d  = o_marker_q;
    o_seq_d     = o_seq_q;
    o_header_d  = o_header_q;
    o_ts_d      = o_ts_q;
    o_dropped_d = o_dropped_q;
    o_run_end_d = o_run_end_q;

    if (o_valid_q && out_chan.ready) o_valid_d = 1'b0;

    if (emit) begin
      o_valid_d = 1'b1;
      if (cur_is_a) begin
        o_offset_d  = x_job_q.a_offset;
        o_length_d  = x_job_q.a_length;
        o_marker_d  = 1'b0;
        o_seq_d     = x_job_q.seq_base;
        o_header_d  = x_job_q.header_word;
        o_ts_d      = ts;
        o_dropped_d = 1'b0;
        o_run_end_d = !x_job_q.has_b;
        x_a_done_d  = 1'b1;
      end else if (x_job_q.b_drop) begin
        o_offset_d  = '0;
        o_length_d  = '0;
        o_marker_d  = 1'b0;
        o_seq_d     = '0;
        o_header_d  = '0;
        o_ts_d      = '0;
        o_dropped_d = 1'b1;
        o_run_end_d = 1'b1;
      end else begin
        o_offset_d  = x_job_q.b_offset;
        o_length_d  = x_job_q.b_length;
        o_marker_d  = 1'b1;
        o_seq_d     = x_job_q.seq_base + 32'(x_job_q.has_a);
        o_header_d  = x_job_q.header_word;
        o_ts_d      = ts;
        o_dropped_d = 1'b0;
        o_run_end_d = 1'b1;
      end
    end

    if (finish) x_valid_d = 1'b0;
    if (pop_o) begin
      x_valid_d  = 1'b1;
      x_a_done_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q  <= 1'b0;
      x_a_done_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      x_valid_q  <= x_valid_d;
      x_a_done_q <= x_a_done_d;
      o_valid_q  <= o_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      x_job_q  <= head_i;
      x_prod_q <= prod;
    end
    o_offset_q  <= o_offset_d;
    o_length_q  <= o_length_d;
    o_marker_q  <= o_marker_d;
    o_seq_q     <= o_seq_d;
    o_header_q  <= o_header_d;
    o_ts_q      <= o_ts_d;
    o_dropped_q <= o_dropped_d;
    o_run_end_q <= o_run_end_d;
  end

  assign out_chan.valid           = o_valid_q;
  assign out_chan.packet_offset   = o_offset_q;
  assign out_chan.packet_length   = o_length_q;
  assign out_chan.marker          = o_marker_q;
  assign out_chan.sequence_number = o_seq_q;
  assign out_chan.header_word     = o_header_q;
  assign out_chan.rtp_timestamp   = o_ts_q;
  assign out_chan.dropped         = o_dropped_q;
  assign out_chan.run_end         = o_run_end_q;

endmodule

`default_nettype wire
